### rtl/particle_quad_vertex_gen_top_macros.svh
// Assertion macros for the particle quad vertex generator.
`ifndef PARTICLE_QUAD_VERTEX_GEN_TOP_MACROS_SVH
`define PARTICLE_QUAD_VERTEX_GEN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PQVG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PQVG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PQVG_ASSERT(lbl, clk, rstn, prop, msg)
`define PQVG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/pqvg_pkg.sv
// Shared types, constants and corner tables of the particle quad vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package pqvg_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned LifeW = 24;
  localparam int unsigned SizeW = 20;
  localparam int unsigned TW = 18;
  localparam int unsigned QW = 18;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned NumCorners = 6;

  localparam logic [CfgIdxW-1:0] CfgStartSize = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEndSize = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgStartColour = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgEndColour = 8'd3;

  localparam logic signed [TW-1:0] TOne = 18'sd65536;
  localparam logic signed [TW-1:0] TMin = -18'sd131072;
  localparam logic [QW-1:0] QMax = 18'd196608;

  localparam logic [2:0] LastCorner = 3'd5;
  localparam logic [NumCorners-1:0] CornerU = 6'b010110;
  localparam logic [NumCorners-1:0] CornerV = 6'b110100;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [TW-1:0]     t;
  } age_t;

  typedef struct packed {
    logic [CoordW-1:0] x_left;
    logic [CoordW-1:0] x_right;
    logic [CoordW-1:0] y_top;
    logic [CoordW-1:0] y_bottom;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
  } quad_t;

endpackage
`default_nettype wire

### rtl/pqvg_div.sv
// Pipelined restoring divider that turns remaining and total life into the age t.
`timescale 1ns / 1ps
`default_nettype none
module pqvg_div import pqvg_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic signed [CoordW-1:0] pos_x_i,
  input  wire logic signed [CoordW-1:0] pos_y_i,
  input  wire logic [LifeW-1:0]         life_left_i,
  input  wire logic [LifeW-1:0]         life_total_i,
  output logic                          valid_o,
  output age_t                          age_o
);

  logic                     valid_q [0:QW];
  logic [LifeW-1:0]         rem_q   [0:QW];
  logic [LifeW-1:0]         life_q  [0:QW];
  logic [LifeW-1:0]         total_q [0:QW];
  logic [QW-1:0]            quo_q   [0:QW];
  logic                     zero_q  [0:QW];
  logic                     ovf_q   [0:QW];
  logic signed [CoordW-1:0] px_q    [0:QW];
  logic signed [CoordW-1:0] py_q    [0:QW];

  logic   out_valid_q;
  age_t   age_q;
  age_t   age_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= {2'b00, life_left_i[LifeW-1:2]};
      life_q[0]  <= life_left_i;
      total_q[0] <= life_total_i;
      quo_q[0]   <= '0;
      zero_q[0]  <= (life_total_i == '0);
      ovf_q[0]   <= ({2'b00, life_left_i} >= {life_total_i, 2'b00});
      px_q[0]    <= pos_x_i;
      py_q[0]    <= pos_y_i;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic              nbit;
    logic [LifeW:0]    shifted;
    logic [LifeW:0]    diff;
    logic              fits;

    if (QW - 1 - i >= 16) begin : g_life_bit
      assign nbit = life_q[i][QW - 1 - i - 16];
    end else begin : g_zero_bit
      assign nbit = 1'b0;
    end

    assign shifted = {rem_q[i], nbit};
    assign diff    = shifted - {1'b0, total_q[i]};
    assign fits    = (shifted >= {1'b0, total_q[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]   <= fits ? diff[LifeW-1:0] : shifted[LifeW-1:0];
        quo_q[i+1]   <= {quo_q[i][QW-2:0], fits};
        life_q[i+1]  <= life_q[i];
        total_q[i+1] <= total_q[i];
        zero_q[i+1]  <= zero_q[i];
        ovf_q[i+1]   <= ovf_q[i];
        px_q[i+1]    <= px_q[i];
        py_q[i+1]    <= py_q[i];
      end
    end
  end

  always_comb begin
    age_d.pos_x = px_q[QW];
    age_d.pos_y = py_q[QW];
    if (zero_q[QW]) begin
      age_d.t = TOne;
    end else if (ovf_q[QW] || (quo_q[QW] > QMax)) begin
      age_d.t = TMin;
    end else begin
      age_d.t = TOne - $signed(quo_q[QW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      age_q <= age_d;
    end
  end

  assign valid_o = out_valid_q;
  assign age_o   = age_q;

endmodule
`default_nettype wire

### rtl/pqvg_interp.sv
// Size and colour interpolation, clamping and corner coordinate saturation.
`timescale 1ns / 1ps
`default_nettype none
module pqvg_interp import pqvg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [SizeW-1:0] start_size_i,
  input  wire logic [SizeW-1:0] end_size_i,
  input  wire logic [31:0]      start_colour_i,
  input  wire logic [31:0]      end_colour_i,
  input  wire logic             valid_i,
  input  age_t                  age_i,
  output logic                  valid_o,
  output quad_t                 quad_o
);

  logic [2:0] valid_q;

  logic signed [SizeW:0]        size_diff;
  logic signed [SizeW+TW:0]     size_prod_q;
  logic signed [8:0]            col_diff   [4];
  logic signed [26:0]           col_prod_q [4];
  logic signed [CoordW-1:0]     px_a_q, py_a_q, px_b_q, py_b_q;

  logic signed [SizeW+4:0]      size_sum;
  logic [SizeW+2:0]             half_q;
  logic signed [11:0]           col_sum  [4];
  logic [7:0]                   col_q    [4];

  logic signed [CoordW+1:0]     xl, xr, yt, yb;
  quad_t                        quad_q;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [CoordW+1:0] v);
    if (v > $signed({3'b000, {(CoordW-1){1'b1}}})) begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < -$signed({3'b001, {(CoordW-1){1'b0}}})) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end
    return v[CoordW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign size_diff = $signed({1'b0, end_size_i}) - $signed({1'b0, start_size_i});

  for (genvar c = 0; c < 4; c++) begin : g_chan
    assign col_diff[c] = $signed({1'b0, end_colour_i[31-8*c -: 8]})
                       - $signed({1'b0, start_colour_i[31-8*c -: 8]});
    assign col_sum[c]  = $signed({4'b0000, start_colour_i[31-8*c -: 8]})
                       + $signed({col_prod_q[c][26], col_prod_q[c][26:16]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        col_prod_q[c] <= col_diff[c] * age_i.t;
        if (col_sum[c] < 0) begin
          col_q[c] <= 8'd0;
        end else if (col_sum[c] > 12'sd255) begin
          col_q[c] <= 8'd255;
        end else begin
          col_q[c] <= col_sum[c][7:0];
        end
      end
    end
  end

  assign size_sum = $signed({5'b00000, start_size_i})
                  + $signed({{2{size_prod_q[SizeW+TW]}}, size_prod_q[SizeW+TW:16]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      size_prod_q <= size_diff * age_i.t;
      px_a_q      <= age_i.pos_x;
      py_a_q      <= age_i.pos_y;
      px_b_q      <= px_a_q;
      py_b_q      <= py_a_q;
      half_q      <= (size_sum < 0) ? '0 : size_sum[SizeW+3:1];
    end
  end

  assign xl = $signed({{2{px_b_q[CoordW-1]}}, px_b_q}) - $signed({3'b000, half_q});
  assign xr = $signed({{2{px_b_q[CoordW-1]}}, px_b_q}) + $signed({3'b000, half_q});
  assign yt = $signed({{2{py_b_q[CoordW-1]}}, py_b_q}) - $signed({3'b000, half_q});
  assign yb = $signed({{2{py_b_q[CoordW-1]}}, py_b_q}) + $signed({3'b000, half_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q.x_left   <= sat_coord(xl);
      quad_q.x_right  <= sat_coord(xr);
      quad_q.y_top    <= sat_coord(yt);
      quad_q.y_bottom <= sat_coord(yb);
      quad_q.red      <= col_q[0];
      quad_q.green    <= col_q[1];
      quad_q.blue     <= col_q[2];
      quad_q.alpha    <= col_q[3];
    end
  end

  assign valid_o = valid_q[2];
  assign quad_o  = quad_q;

endmodule
`default_nettype wire

### rtl/pqvg_emit.sv
// Output buffer that holds one quad and sends its six vertices in triangle order.
`timescale 1ns / 1ps
`default_nettype none
module pqvg_emit import pqvg_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  quad_t      quad_i,
  output logic       ready_o,
  output logic       valid_o,
  input  wire logic  take_i,
  output logic [CoordW-1:0] vert_x_o,
  output logic [CoordW-1:0] vert_y_o,
  output logic       tex_u_o,
  output logic       tex_v_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       last_o
);

  logic       full_q;
  logic [2:0] cnt_q;
  quad_t      quad_q;
  logic       last;

  assign last    = (cnt_q == LastCorner);
  assign ready_o = !full_q || (take_i && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      full_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take_i && full_q) begin
      full_q <= !last;
      cnt_q  <= last ? 3'd0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quad_q <= quad_i;
    end
  end

  assign valid_o  = full_q;
  assign tex_u_o  = CornerU[cnt_q];
  assign tex_v_o  = CornerV[cnt_q];
  assign vert_x_o = tex_u_o ? quad_q.x_right : quad_q.x_left;
  assign vert_y_o = tex_v_o ? quad_q.y_bottom : quad_q.y_top;
  assign red_o    = quad_q.red;
  assign green_o  = quad_q.green;
  assign blue_o   = quad_q.blue;
  assign alpha_o  = quad_q.alpha;
  assign last_o   = last;

endmodule
`default_nettype wire

### rtl/particle_quad_vertex_gen_top.sv
// The output sends one vertex word per cycle while m_axis_tready_i is high, six words per particle.
// The 23-stage divide and interpolate pipeline takes a particle every cycle until the
// six-vertex output buffer stalls it; a stall freezes every stage at once.
// Reset is asynchronous and active low; it empties the pipeline and restores the registers.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_quad_vertex_gen_top_macros.svh"
module particle_quad_vertex_gen_top import pqvg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // pos_x, pos_y, life_left, life_total
  input  wire logic [95:0]        s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // vert_x, vert_y, tex_u, tex_v, red, green, blue, alpha, zero padding
  output logic [87:0]             m_axis_tdata_o,
  output logic                    m_axis_tlast_o
);

  logic [SizeW-1:0] start_size_q, end_size_q;
  logic [31:0]      start_colour_q, end_colour_q;

  logic        en;
  logic        div_valid, int_valid;
  age_t        age;
  quad_t       quad;
  logic [CoordW-1:0] vert_x, vert_y;
  logic        tex_u, tex_v;
  logic [7:0]  red, green, blue, alpha;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_size_q   <= '0;
      end_size_q     <= '0;
      start_colour_q <= 32'hFFFF_FFFF;
      end_colour_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStartSize:   start_size_q   <= cfg_data_i[SizeW-1:0];
        CfgEndSize:     end_size_q     <= cfg_data_i[SizeW-1:0];
        CfgStartColour: start_colour_q <= cfg_data_i;
        CfgEndColour:   end_colour_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = en;

  pqvg_div u_div (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .valid_i      (s_axis_tvalid_i),
    .pos_x_i      (s_axis_tdata_i[23:0]),
    .pos_y_i      (s_axis_tdata_i[47:24]),
    .life_left_i  (s_axis_tdata_i[71:48]),
    .life_total_i (s_axis_tdata_i[95:72]),
    .valid_o      (div_valid),
    .age_o        (age)
  );

  pqvg_interp u_interp (
    .clk_i,
    .rst_ni,
    .en_i           (en),
    .start_size_i   (start_size_q),
    .end_size_i     (end_size_q),
    .start_colour_i (start_colour_q),
    .end_colour_i   (end_colour_q),
    .valid_i        (div_valid),
    .age_i          (age),
    .valid_o        (int_valid),
    .quad_o         (quad)
  );

  pqvg_emit u_emit (
    .clk_i,
    .rst_ni,
    .load_i   (en && int_valid),
    .quad_i   (quad),
    .ready_o  (en),
    .valid_o  (m_axis_tvalid_o),
    .take_i   (m_axis_tready_i),
    .vert_x_o (vert_x),
    .vert_y_o (vert_y),
    .tex_u_o  (tex_u),
    .tex_v_o  (tex_v),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue),
    .alpha_o  (alpha),
    .last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b000000, alpha, blue, green, red, tex_v, tex_u, vert_y, vert_x};

  `PQVG_ASSERT(a_last_is_bl, clk_i, rst_ni, !(m_axis_tvalid_o && m_axis_tlast_o) || (m_axis_tdata_o[48] == 1'b0 && m_axis_tdata_o[49] == 1'b1), "last vertex is not the bottom-left corner")
  `PQVG_ASSERT(a_stall_cause, clk_i, rst_ni, s_axis_tready_o || m_axis_tvalid_o, "input stalled with no pending output word")
  `PQVG_ASSERT_NEXT(a_quad_continues, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o, "quad dropped before its last vertex")

endmodule
`default_nettype wire

### dv/tb_particle_quad_vertex_gen_top.sv
// Testbench for the particle quad vertex generator: directed and random particles checked
// against an in-bench model of the quad expansion under several register settings.
`timescale 1ns / 1ps
module tb_particle_quad_vertex_gen_top;
  import pqvg_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgTopIdx = 8'd255;
  localparam int DrainCycles = 40;
  localparam int WatchdogLimit = 20000;
  localparam int ItemsPerPhase = 70;
  localparam int NumPhases = 5;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    logic [23:0] vx;
    logic [23:0] vy;
    logic        u;
    logic        v;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] life;
    logic [23:0] total;
    bit          typed;
    logic [7:0]  colour;
  } particle_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // pos_x, pos_y, life_left, life_total
  logic [95:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // vert_x, vert_y, tex_u, tex_v, red, green, blue, alpha, zero padding
  logic [87:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  logic [19:0] start_size_q;
  logic [19:0] end_size_q;
  logic [31:0] start_colour_q;
  logic [31:0] end_colour_q;

  vertex_t pending_verts[$];
  idle_mode_e idle_mode = IdleNone;
  int errors = 0;
  int particles_sent = 0;
  int verts_checked = 0;
  int quiet_cycles = 0;

  particle_quad_vertex_gen_top u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] blend(logic [7:0] from, logic [7:0] to, longint t);
    longint c;
    c = longint'(from) + ((longint'(to) - longint'(from)) * t >>> 16);
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return c[7:0];
  endfunction

  function automatic logic [23:0] sat24(longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  task automatic expand_particle(logic [23:0] px, logic [23:0] py, logic [23:0] life,
                                 logic [23:0] total);
    longint t, sz, half, x0, y0;
    longint unsigned q;
    logic [23:0] xs[2];
    logic [23:0] ys[2];
    logic [7:0] ch[4];
    vertex_t vert;
    if (total == 0) begin
      t = 65536;
    end else begin
      q = (longint'(life) << 16) / longint'(total);
      t = (q > 196608) ? -131072 : 65536 - longint'(q);
    end
    sz = longint'(start_size_q) + ((longint'(end_size_q) - longint'(start_size_q)) * t >>> 16);
    if (sz < 0) sz = 0;
    half = sz >>> 1;
    x0 = longint'($signed(px));
    y0 = longint'($signed(py));
    xs[0] = sat24(x0 - half);
    xs[1] = sat24(x0 + half);
    ys[0] = sat24(y0 - half);
    ys[1] = sat24(y0 + half);
    for (int i = 0; i < 4; i++) begin
      ch[i] = blend(start_colour_q[24-8*i +: 8], end_colour_q[24-8*i +: 8], t);
    end
    for (int k = 0; k < NumCorners; k++) begin
      vert.u = CornerU[k];
      vert.v = CornerV[k];
      vert.vx = xs[vert.u];
      vert.vy = ys[vert.v];
      vert.r = ch[0];
      vert.g = ch[1];
      vert.b = ch[2];
      vert.a = ch[3];
      vert.last = (k == LastCorner);
      pending_verts = {pending_verts, vert};
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    bit rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    case (idx)
      CfgStartSize:   start_size_q = data[19:0];
      CfgEndSize:     end_size_q = data[19:0];
      CfgStartColour: start_colour_q = data;
      CfgEndColour:   end_colour_q = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [19:0] s0, logic [19:0] s1, logic [31:0] c0,
                               logic [31:0] c1);
    write_reg(CfgStartSize, {12'hABC, s0});
    write_reg(CfgEndSize, {12'h543, s1});
    write_reg(CfgStartColour, c0);
    write_reg(CfgEndColour, c1);
    write_reg(CfgUnusedIdx, $urandom);
    write_reg(CfgTopIdx, $urandom);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_verts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sends one particle; the expectation is queued at the accepting edge.
  task automatic send_particle(particle_row_t p);
    bit rdy;
    vertex_t vert;
    while ((idle_mode == IdleSender && $urandom_range(99) < 53) ||
           (idle_mode == IdleBoth && $urandom_range(99) < 11)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {p.total, p.life, p.py, p.px};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    particles_sent++;
    if (p.typed) begin
      for (int k = 0; k < NumCorners; k++) begin
        vert.u = CornerU[k];
        vert.v = CornerV[k];
        vert.vx = p.px;
        vert.vy = p.py;
        vert.r = p.colour;
        vert.g = p.colour;
        vert.b = p.colour;
        vert.a = p.colour;
        vert.last = (k == LastCorner);
        pending_verts = {pending_verts, vert};
      end
    end else begin
      expand_particle(p.px, p.py, p.life, p.total);
    end
  endtask

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic particle_row_t random_particle();
    particle_row_t p;
    p.px = pick_pos();
    p.py = pick_pos();
    p.typed = 1'b0;
    p.colour = '0;
    case ($urandom_range(15))
      0: begin
        p.total = '0;
        p.life = 24'($urandom);
      end
      1: begin
        p.total = 24'd1;
        p.life = 24'($urandom);
      end
      2, 3: begin
        p.total = 24'($urandom_range(1, 24'hFFFFFF));
        p.life = 24'($urandom_range(p.total, 24'hFFFFFF));
      end
      default: begin
        p.total = 24'($urandom_range(1, 24'hFFFFFF));
        p.life = 24'($urandom_range(0, p.total));
      end
    endcase
    return p;
  endfunction

  always @(posedge clk_i) begin
    case (idle_mode)
      IdleReceiver: m_axis_tready_i <= ($urandom_range(99) >= 53);
      IdleBoth:     m_axis_tready_i <= ($urandom_range(99) >= 11);
      default:      m_axis_tready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verts.size() == 0) begin
        $error("vertex word with nothing expected: %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_verts.pop_front();
        verts_checked++;
        if (m_axis_tdata_o[23:0] !== want.vx) begin
          $error("vert_x: expected %h, got %h", want.vx, m_axis_tdata_o[23:0]);
          errors++;
        end
        if (m_axis_tdata_o[47:24] !== want.vy) begin
          $error("vert_y: expected %h, got %h", want.vy, m_axis_tdata_o[47:24]);
          errors++;
        end
        if (m_axis_tdata_o[48] !== want.u) begin
          $error("tex_u: expected %b, got %b", want.u, m_axis_tdata_o[48]);
          errors++;
        end
        if (m_axis_tdata_o[49] !== want.v) begin
          $error("tex_v: expected %b, got %b", want.v, m_axis_tdata_o[49]);
          errors++;
        end
        if (m_axis_tdata_o[57:50] !== want.r) begin
          $error("red: expected %h, got %h", want.r, m_axis_tdata_o[57:50]);
          errors++;
        end
        if (m_axis_tdata_o[65:58] !== want.g) begin
          $error("green: expected %h, got %h", want.g, m_axis_tdata_o[65:58]);
          errors++;
        end
        if (m_axis_tdata_o[73:66] !== want.b) begin
          $error("blue: expected %h, got %h", want.b, m_axis_tdata_o[73:66]);
          errors++;
        end
        if (m_axis_tdata_o[81:74] !== want.a) begin
          $error("alpha: expected %h, got %h", want.a, m_axis_tdata_o[81:74]);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_vertex: expected %b, got %b", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("particle_quad_vertex_gen_top test failed");
      $finish;
    end
  end

  initial begin
    particle_row_t rows[$];
    particle_row_t p;
    rows = '{
      '{24'h000000, 24'h000000, 24'h001000, 24'h001000, 1'b1, 8'hFF},
      '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 1'b1, 8'h00},
      '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 1'b1, 8'h00},
      '{24'h123456, 24'hFEDCBA, 24'h000000, 24'hFFFFFF, 1'b1, 8'h00},
      '{24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 8'hFF},
      '{24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'h000001, 1'b1, 8'hFF},
      '{24'hAAAAAA, 24'h555555, 24'h003000, 24'h002000, 1'b1, 8'hFF},
      '{24'h000100, 24'hFFFF00, 24'h000800, 24'h001000, 1'b0, 8'h00},
      '{24'h400000, 24'hC00000, 24'h000001, 24'h000003, 1'b0, 8'h00},
      '{24'h0F0F0F, 24'hF0F0F0, 24'h2AAAAA, 24'h3FFFFF, 1'b0, 8'h00}
    };
    start_size_q = 20'd0;
    end_size_q = 20'd0;
    start_colour_q = 32'hFFFFFFFF;
    end_colour_q = 32'h0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_particle(rows[i]);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    load_settings(20'hFFFFF, 20'h00000, 32'h00FF80FF, 32'hFF007F00);
    for (int i = 0; i < 6; i++) begin
      p = rows[i];
      p.typed = 1'b0;
      send_particle(p);
    end
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_settings(20'h00000, 20'hFFFFF, 32'h00000000, 32'hFFFFFFFF);
        1: load_settings(20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        default: load_settings(20'($urandom), 20'($urandom), $urandom, $urandom);
      endcase
      idle_mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (ph == 2 && n == ItemsPerPhase / 2) begin
          s_axis_tvalid_i <= 1'b0;
          while (pending_verts.size() != 0) @(posedge clk_i);
        end
        send_particle(random_particle());
      end
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
    end

    $display("Sent %0d particles and checked %0d vertex words.", particles_sent,
             verts_checked);
    $display("Covered register extremes, zero and exceeded life, saturated edges and stalls.");
    if (errors == 0) begin
      $display("particle_quad_vertex_gen_top test passed");
    end else begin
      $display("particle_quad_vertex_gen_top test failed");
    end
    $finish;
  end

endmodule
